// File: hw/rtl/fist_pkg.sv
// Package for the floppy image sector tracker.
// Holds the transaction payload types, command and access codes, default
// geometry and the controller/datapath handshake types. No dependencies.
package fist_pkg;

    // Default geometry, handed to the top level parameters.
    localparam int NUM_DRIVES_DEF        = 4;
    localparam int NUM_TRACKS_DEF        = 154;
    localparam int SECTORS_PER_TRACK_DEF = 8;

    // Width of the drive loaded register.
    localparam int LOADED_W = 4;

    // Command codes.
    localparam logic [2:0] CMD_SEEK      = 3'd0;
    localparam logic [2:0] CMD_GET_ID    = 3'd1;
    localparam logic [2:0] CMD_READ_ID   = 3'd2;
    localparam logic [2:0] CMD_READ      = 3'd3;
    localparam logic [2:0] CMD_READ_DIAG = 3'd4;
    localparam logic [2:0] CMD_WRITE     = 3'd5;
    localparam logic [2:0] CMD_WRITE_ID  = 3'd6;

    // Data access kinds.
    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_READ  = 2'd1;
    localparam logic [1:0] ACC_WRITE = 2'd2;

    // Fixed ID size code (1024 byte sectors) and write-ID list limit.
    localparam logic [7:0] SIZE_CODE = 8'd3;
    localparam logic [3:0] LIST_MAX  = 4'd15;

    // Input transaction payload.
    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] drive;
        logic [7:0] track;
        logic [7:0] id_cyl;
        logic [7:0] id_head;
        logic [7:0] id_record;
        logic [7:0] id_size;
        logic       id_last;
    } in_t;

    // Result transaction payload.
    typedef struct packed {
        logic        ok;
        logic [6:0]  out_cyl;
        logic        out_head;
        logic [3:0]  out_record;
        logic [1:0]  out_size;
        logic [10:0] sector_index;
        logic [1:0]  data_access;
    } out_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_result;
    } status_t;

endpackage

// File: hw/rtl/fist_ctrl.sv
// Controller of the floppy image sector tracker.
// Sequences capture and execution of each command and owns the result
// valid flag. Depends on fist_pkg.
module fist_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  fist_pkg::status_t status,
    output fist_pkg::ctrl_t  ctrl
);
    import fist_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    // State and result valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and command outputs.
    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.execute = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Execute once the result register is free or being drained.
                if (!m_valid_reg || m_ready) begin
                    ctrl.execute = 1'b1;
                    m_valid_next = status.has_result;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// File: hw/rtl/fist_dp.sv
// Datapath of the floppy image sector tracker.
// Holds the loaded mask, the captured command, per-drive track and sector
// state, the write-ID list state and the result register. Depends on fist_pkg.
module fist_dp #(
    parameter int NUM_DRIVES        = fist_pkg::NUM_DRIVES_DEF,
    parameter int NUM_TRACKS        = fist_pkg::NUM_TRACKS_DEF,
    parameter int SECTORS_PER_TRACK = fist_pkg::SECTORS_PER_TRACK_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [fist_pkg::LOADED_W-1:0]  cfg_wr_data,
    input  fist_pkg::in_t                  s_data,
    output fist_pkg::out_t                 m_data,
    input  fist_pkg::ctrl_t                ctrl,
    output fist_pkg::status_t              status
);
    import fist_pkg::*;

    localparam int DRV_W = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;
    localparam int SEC_W = (SECTORS_PER_TRACK > 1) ? $clog2(SECTORS_PER_TRACK) : 1;

    logic [LOADED_W-1:0] loaded_reg;
    in_t                 cmd_reg;
    out_t                out_reg;
    out_t                res;
    logic [7:0]          track_pos_reg   [NUM_DRIVES];
    logic [SEC_W-1:0]    next_sector_reg [NUM_DRIVES];
    logic [3:0]          list_count_reg;
    logic [3:0]          list_count_next;
    logic                list_fail_reg;
    logic                list_fail_next;

    logic [DRV_W-1:0]    drv_idx;
    logic [7:0]          tp;
    logic [SEC_W-1:0]    cur;
    logic                drive_ok;
    logic                trk_ok;
    logic                tp_ok;
    logic [9:0]          chs_sum;
    logic                rec_ok;
    logic                size_ok;
    logic                entry_ok;
    logic                rw_ok;
    logic                list_good;
    logic [4:0]          cur_plus1;
    logic [SEC_W-1:0]    cur_adv;
    logic [SEC_W-1:0]    seek_sector;
    logic [SEC_W-1:0]    rw_sector;
    logic [11:0]         diag_index;
    logic [11:0]         rw_index;
    logic                tp_we;
    logic [7:0]          tp_wdata;
    logic                ns_we;
    logic [SEC_W-1:0]    ns_wdata;
    logic                has_result;

    // Drive loaded mask, written by the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg <= '0;
        end else if (cfg_wr_en) begin
            loaded_reg <= cfg_wr_data;
        end
    end

    // Captured command.
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            cmd_reg <= s_data;
        end
    end

    // Lookups and checks on the captured command.
    assign drv_idx   = cmd_reg.drive[DRV_W-1:0];
    assign tp        = track_pos_reg[drv_idx];
    assign cur       = next_sector_reg[drv_idx];
    assign drive_ok  = (4'(cmd_reg.drive) < 4'(NUM_DRIVES)) && !cmd_reg.drive[2]
                       && loaded_reg[cmd_reg.drive[1:0]];
    assign trk_ok    = 9'(cmd_reg.track) < 9'(NUM_TRACKS);
    assign tp_ok     = 9'(tp) < 9'(NUM_TRACKS);
    assign chs_sum   = {1'b0, cmd_reg.id_cyl, 1'b0} + 10'(cmd_reg.id_head);
    assign rec_ok    = (cmd_reg.id_record != 8'd0)
                       && (cmd_reg.id_record <= 8'(SECTORS_PER_TRACK));
    assign size_ok   = cmd_reg.id_size == SIZE_CODE;
    assign entry_ok  = (chs_sum == 10'(cmd_reg.track)) && rec_ok && size_ok;
    assign rw_ok     = (chs_sum == 10'(tp)) && (cmd_reg.id_head <= 8'd1) && rec_ok && size_ok;
    assign list_good = !list_fail_reg && entry_ok
                       && ((5'(list_count_reg) + 5'd1) == 5'(SECTORS_PER_TRACK))
                       && drive_ok && trk_ok;

    // Sector arithmetic.
    assign cur_plus1   = 5'(cur) + 5'd1;
    assign cur_adv     = (cur_plus1 >= 5'(SECTORS_PER_TRACK)) ? '0 : SEC_W'(cur_plus1);
    assign seek_sector = (tp != cmd_reg.track) ? '0 : cur;
    assign rw_sector   = (cmd_reg.id_record >= 8'(SECTORS_PER_TRACK))
                         ? '0 : SEC_W'(cmd_reg.id_record);
    assign diag_index  = 12'(tp) * 12'(SECTORS_PER_TRACK) + 12'(cur);
    assign rw_index    = 12'(tp) * 12'(SECTORS_PER_TRACK) + 12'(cmd_reg.id_record) - 12'd1;

    // Command decode: result and state updates.
    always_comb begin
        res             = '0;
        has_result      = 1'b1;
        tp_we           = 1'b0;
        tp_wdata        = cmd_reg.track;
        ns_we           = 1'b0;
        ns_wdata        = cur_adv;
        list_count_next = list_count_reg;
        list_fail_next  = list_fail_reg;
        case (cmd_reg.cmd)
            CMD_WRITE_ID: begin
                if (!entry_ok) begin
                    list_fail_next = 1'b1;
                end
                if (!cmd_reg.id_last) begin
                    has_result = 1'b0;
                    if (list_count_reg == LIST_MAX) begin
                        list_fail_next = 1'b1;
                    end else begin
                        list_count_next = list_count_reg + 4'd1;
                    end
                end else begin
                    list_count_next = '0;
                    list_fail_next  = 1'b0;
                    tp_we           = list_good;
                    res.ok          = list_good;
                end
            end
            CMD_SEEK: begin
                if (drive_ok && trk_ok) begin
                    tp_we          = 1'b1;
                    ns_we          = 1'b1;
                    ns_wdata       = seek_sector;
                    res.ok         = 1'b1;
                    res.out_cyl    = cmd_reg.track[7:1];
                    res.out_head   = cmd_reg.track[0];
                    res.out_record = 4'(5'(seek_sector) + 5'd1);
                    res.out_size   = SIZE_CODE[1:0];
                end
            end
            CMD_GET_ID, CMD_READ_ID, CMD_READ_DIAG: begin
                if (drive_ok && tp_ok) begin
                    ns_we          = cmd_reg.cmd != CMD_GET_ID;
                    res.ok         = 1'b1;
                    res.out_cyl    = tp[7:1];
                    res.out_head   = tp[0];
                    res.out_record = 4'(cur_plus1);
                    res.out_size   = SIZE_CODE[1:0];
                    if (cmd_reg.cmd == CMD_READ_DIAG) begin
                        res.sector_index = diag_index[10:0];
                        res.data_access  = ACC_READ;
                    end
                end
            end
            CMD_READ, CMD_WRITE: begin
                if (drive_ok && tp_ok && rw_ok) begin
                    ns_we            = 1'b1;
                    ns_wdata         = rw_sector;
                    res.ok           = 1'b1;
                    res.out_cyl      = tp[7:1];
                    res.out_head     = tp[0];
                    res.out_record   = cmd_reg.id_record[3:0];
                    res.out_size     = SIZE_CODE[1:0];
                    res.sector_index = rw_index[10:0];
                    res.data_access  = (cmd_reg.cmd == CMD_READ) ? ACC_READ : ACC_WRITE;
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    // Per-drive state and write-ID list state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_DRIVES; i++) begin
                track_pos_reg[i]   <= '0;
                next_sector_reg[i] <= '0;
            end
            list_count_reg <= '0;
            list_fail_reg  <= 1'b0;
        end else if (ctrl.execute) begin
            if (tp_we) begin
                track_pos_reg[drv_idx] <= tp_wdata;
            end
            if (ns_we) begin
                next_sector_reg[drv_idx] <= ns_wdata;
            end
            list_count_reg <= list_count_next;
            list_fail_reg  <= list_fail_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (ctrl.execute && has_result) begin
            out_reg <= res;
        end
    end

    assign m_data            = out_reg;
    assign status.has_result = has_result;

endmodule

// File: hw/rtl/floppy_image_sector_tracker_top.sv
// ST_IDLE captures each command; ST_EXEC checks it against the per-drive track
// and sector registers, updates them and loads the result register. A new
// command is taken while a finished result still waits on the output. A
// write-ID entry that is not the last one of its list gives no result
// transaction; every other command gives exactly one. The drive loaded mask
// may only be written while no command is in flight.
//
// Top level of the floppy image sector tracker.
// Joins the controller and the datapath. Depends on fist_pkg, fist_ctrl, fist_dp.
module floppy_image_sector_tracker_top #(
    parameter int NUM_DRIVES        = fist_pkg::NUM_DRIVES_DEF,
    parameter int NUM_TRACKS        = fist_pkg::NUM_TRACKS_DEF,
    parameter int SECTORS_PER_TRACK = fist_pkg::SECTORS_PER_TRACK_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [fist_pkg::LOADED_W-1:0] cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  fist_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output fist_pkg::out_t                m_data
);
    import fist_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    // Command sequencing.
    fist_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    // Tracking state and result formation.
    fist_dp #(
        .NUM_DRIVES        (NUM_DRIVES),
        .NUM_TRACKS        (NUM_TRACKS),
        .SECTORS_PER_TRACK (SECTORS_PER_TRACK)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_data      (m_data),
        .ctrl        (ctrl),
        .status      (status)
    );

endmodule
